// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbp assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbp assertion failed");

`endif

// ===== rtl/hbp_pkg.sv =====
// ---------------------------------------------------------------------------
// Halo box partitioner package
// Sizes, payload layouts and controller/datapath interface types.
// ---------------------------------------------------------------------------
package hbp_pkg;

  localparam int NUM_AXES   = 3;
  localparam int COORD_BITS = 16;
  localparam int AXES_USED  = (NUM_AXES < 1) ? 1 : ((NUM_AXES > 3) ? 3 : NUM_AXES);
  localparam int FIELD_W    = 16;
  localparam int AXIS_SLOTS = 3;

  typedef logic [FIELD_W-1:0] coord_t;
  typedef logic [FIELD_W:0]   coord_sum_t;
  typedef logic [1:0]         digit_t;
  typedef logic [2:0]         piece_mask_t;

  localparam digit_t DIG_LEFT   = 2'd0;
  localparam digit_t DIG_CENTER = 2'd1;
  localparam digit_t DIG_RIGHT  = 2'd2;

  localparam coord_t COORD_MASK = (COORD_BITS >= FIELD_W) ? {FIELD_W{1'b1}} :
                                  coord_t'((33'd1 << COORD_BITS) - 33'd1);

  // first member sits in the highest bits
  typedef struct packed {
    logic [AXIS_SLOTS-1:0][FIELD_W-1:0] start;
    logic [AXIS_SLOTS-1:0][FIELD_W-1:0] size;
    logic [AXIS_SLOTS-1:0][FIELD_W-1:0] outer;
  } box_t;

  typedef struct packed {
    logic [AXIS_SLOTS-1:0][FIELD_W-1:0] size;
    logic [AXIS_SLOTS-1:0][FIELD_W-1:0] start;
  } seg_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic emit;
  } hbp_cmd_t;

  typedef struct packed {
    logic box_err;
    logic seg_valid;
    logic walk_done;
  } hbp_stat_t;

endpackage

// ===== rtl/hbp_datapath.sv =====
// ---------------------------------------------------------------------------
// Halo box partitioner datapath
// Box registers, cut points, piece masks, base-3 piece counter, result register.
// ---------------------------------------------------------------------------
module hbp_datapath (
  input  logic              clk,
  input  hbp_pkg::box_t     box_in,
  input  hbp_pkg::hbp_cmd_t cmd,
  output hbp_pkg::hbp_stat_t stat,
  output hbp_pkg::seg_t     seg_out,
  output logic              seg_last,
  output logic              seg_err
);
  import hbp_pkg::*;

  coord_t      outer     [AXIS_SLOTS];
  coord_t      start     [AXIS_SLOTS];
  coord_t      size      [AXIS_SLOTS];
  coord_t      cut_end   [AXIS_SLOTS];
  piece_mask_t mask      [AXIS_SLOTS];
  digit_t      digit     [AXIS_SLOTS];
  logic        box_err;

  coord_t      outer_next   [AXIS_SLOTS];
  coord_t      start_next   [AXIS_SLOTS];
  coord_t      size_next    [AXIS_SLOTS];
  coord_sum_t  end_sum      [AXIS_SLOTS];
  piece_mask_t mask_next    [AXIS_SLOTS];
  digit_t      digit_next   [AXIS_SLOTS];
  logic        box_err_next;

  seg_t        seg_cur;
  logic        cur_valid;
  logic        cur_last;
  logic        all_right;
  logic        any_empty;
  logic        carry;
  digit_t      hi_digit;

  always_comb begin
    box_err_next = 1'b0;
    for (int a = 0; a < AXIS_SLOTS; a++) begin
      if (a < AXES_USED) begin
        outer_next[a] = box_in.outer[a] & COORD_MASK;
        start_next[a] = box_in.start[a] & COORD_MASK;
        size_next[a]  = box_in.size[a] & COORD_MASK;
      end else begin
        outer_next[a] = '0;
        start_next[a] = '0;
        size_next[a]  = '0;
      end
      end_sum[a] = {1'b0, start_next[a]} + {1'b0, size_next[a]};
      if (end_sum[a] > {1'b0, outer_next[a]}) begin
        box_err_next = 1'b1;
      end
      if (a < AXES_USED) begin
        mask_next[a] = {end_sum[a] != {1'b0, outer_next[a]},
                        size_next[a] != '0,
                        start_next[a] != '0};
      end else begin
        mask_next[a] = 3'b001;
      end
    end
  end

  always_comb begin
    cur_valid = 1'b1;
    cur_last  = 1'b1;
    all_right = 1'b1;
    any_empty = 1'b0;
    seg_cur   = '0;
    for (int a = 0; a < AXIS_SLOTS; a++) begin
      hi_digit = mask[a][2] ? DIG_RIGHT : (mask[a][1] ? DIG_CENTER : DIG_LEFT);
      if (!mask[a][digit[a]]) cur_valid = 1'b0;
      if (digit[a] != hi_digit) cur_last = 1'b0;
      if (mask[a] == '0) any_empty = 1'b1;
      if (a < AXES_USED && digit[a] != DIG_RIGHT) all_right = 1'b0;
      unique case (digit[a])
        DIG_LEFT: begin
          seg_cur.start[a] = '0;
          seg_cur.size[a]  = start[a];
        end
        DIG_CENTER: begin
          seg_cur.start[a] = start[a];
          seg_cur.size[a]  = size[a];
        end
        default: begin
          seg_cur.start[a] = cut_end[a];
          seg_cur.size[a]  = outer[a] - cut_end[a];
        end
      endcase
    end
  end

  // base-3 increment, highest used axis least significant
  always_comb begin
    carry = 1'b1;
    for (int a = AXIS_SLOTS - 1; a >= 0; a--) begin
      digit_next[a] = digit[a];
      if (a < AXES_USED && carry) begin
        if (digit[a] == DIG_RIGHT) begin
          digit_next[a] = DIG_LEFT;
        end else begin
          digit_next[a] = digit[a] + 2'd1;
          carry = 1'b0;
        end
      end
    end
  end

  assign stat.box_err   = box_err;
  assign stat.seg_valid = cur_valid;
  assign stat.walk_done = all_right || any_empty;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_err <= box_err_next;
      for (int a = 0; a < AXIS_SLOTS; a++) begin
        outer[a]   <= outer_next[a];
        start[a]   <= start_next[a];
        size[a]    <= size_next[a];
        cut_end[a] <= end_sum[a][FIELD_W-1:0];
        mask[a]    <= mask_next[a];
        digit[a]   <= DIG_LEFT;
      end
    end else if (cmd.advance) begin
      for (int a = 0; a < AXIS_SLOTS; a++) begin
        digit[a] <= digit_next[a];
      end
    end
    if (cmd.emit) begin
      seg_out  <= box_err ? '0 : seg_cur;
      seg_last <= box_err || cur_last;
      seg_err  <= box_err;
    end
  end

endmodule

// ===== rtl/hbp_ctrl.sv =====
// ---------------------------------------------------------------------------
// Halo box partitioner controller
// Accepts a box, steps the piece walk and owns the result valid flag.
// ---------------------------------------------------------------------------
module hbp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  hbp_pkg::hbp_stat_t stat,
  output hbp_pkg::hbp_cmd_t  cmd
);
  import hbp_pkg::*;

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t state;
  logic   can_adv;
  logic   done;

  assign in_ready    = (state == S_IDLE);
  assign can_adv     = !out_valid || out_ready;
  assign done        = stat.box_err || stat.walk_done;
  assign cmd.load    = in_ready && in_valid;
  assign cmd.advance = (state == S_WALK) && can_adv;
  assign cmd.emit    = cmd.advance && (stat.box_err || stat.seg_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_WALK;
        end
        S_WALK: begin
          if (cmd.advance && done) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/halo_box_partitioner.sv =====
// ---------------------------------------------------------------------------
// Halo box partitioner
// Cuts each axis of a box into left, centre and right pieces and streams
// every non-empty sub-box, or one error transaction if the inner box spills.
// Throughput: the base-3 piece counter visits all 27 pieces at one per cycle
// while the output is not stalled, and a new box is accepted only after the
// walk ends; an error or empty box ends the walk at its first step.
// Reset: synchronous; clears the controller state and the result valid flag.
// ---------------------------------------------------------------------------
module halo_box_partitioner (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // outer_size_a0..a2, inner_size_a0..a2, inner_start_a0..a2
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // seg_start_a0..a2, seg_size_a0..a2
  output logic [95:0]  m_tdata,
  output logic         m_tlast,
  // box_error
  output logic [0:0]   m_tuser
);
  import hbp_pkg::*;

  hbp_cmd_t  cmd;
  hbp_stat_t stat;
  seg_t      seg;

  hbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hbp_datapath u_dp (
    .clk      (clk),
    .box_in   (box_t'(s_tdata)),
    .cmd      (cmd),
    .stat     (stat),
    .seg_out  (seg),
    .seg_last (m_tlast),
    .seg_err  (m_tuser[0])
  );

  assign m_tdata = seg;

endmodule

// ===== rtl/hbp_checker.sv =====
// ---------------------------------------------------------------------------
// Halo box partitioner checker
// Port-level properties of the partitioner, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hbp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic         m_tlast,
  input logic [0:0]   m_tuser
);

  logic [97:0] m_word;

  assign m_word = {m_tuser, m_tlast, m_tdata};

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_word))
  `ASSERT_IMPLY(a_err_shape, clk, rst, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 96'd0))
  `ASSERT_IMPLY(a_seg_size, clk, rst, m_tvalid && !m_tuser[0], m_tdata[63:48] != 16'd0)
  `ASSERT_IMPLY(a_no_accept_mid_box, clk, rst, m_tvalid && !m_tlast, !s_tready)

endmodule

bind halo_box_partitioner hbp_checker u_hbp_checker (.*);
